>>> hdl/mdss_pkg.sv
// Shared types and constants for the MPPT duty sweep search unit.
// No dependencies; every other file of the block imports this package.
package mdss_pkg;

  // Sample path
  localparam int ADC_BITS            = 10;
  localparam int SAMPLES_PER_AVERAGE = 32;
  localparam int AVG_SHIFT           = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SUM_BITS            = ADC_BITS + AVG_SHIFT;
  localparam int CNT_BITS            = AVG_SHIFT;

  // Duty path
  localparam int DUTY_BITS = 11;
  localparam int STEP_BITS = 8;

  // Configuration port
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  // Register reset values
  localparam logic [DUTY_BITS-1:0] SWEEP_START_RST  = DUTY_BITS'(500);
  localparam logic [STEP_BITS-1:0] DUTY_STEP_RST    = STEP_BITS'(5);
  localparam logic [DUTY_BITS-1:0] DUTY_MAX_RST     = DUTY_BITS'(2000);
  localparam logic [DUTY_BITS-1:0] INITIAL_DUTY_RST = DUTY_BITS'(1460);

  typedef logic [ADC_BITS-1:0]  sample_t;
  typedef logic [DUTY_BITS-1:0] duty_t;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SWEEP_START  = 2'd0,
    CFG_DUTY_STEP    = 2'd1,
    CFG_DUTY_MAX     = 2'd2,
    CFG_INITIAL_DUTY = 2'd3
  } cfg_index_t;

  // Input action codes
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_START  = 1'b1
  } action_t;

  // Averager to sweep controller / result register
  typedef struct packed {
    logic    valid;
    sample_t voltage;
    sample_t current;
  } avg_result_t;

  // Sweep controller to result register
  typedef struct packed {
    duty_t duty;
    logic  sweeping;
    logic  done;
  } sweep_status_t;

endpackage

>>> hdl/mdss_if.sv
// Valid/ready channel interfaces for sample items and result items.
// Depends on mdss_pkg for the payload types.
interface mdss_sample_if;
  import mdss_pkg::*;
  logic    valid;
  logic    ready;
  logic    action;
  sample_t voltage_sample;
  sample_t current_sample;
  modport source (output valid, action, voltage_sample, current_sample, input ready);
  modport sink   (input valid, action, voltage_sample, current_sample, output ready);
endinterface

interface mdss_result_if;
  import mdss_pkg::*;
  logic    valid;
  logic    ready;
  duty_t   duty;
  logic    sweeping;
  logic    sweep_done;
  logic    average_valid;
  sample_t average_voltage;
  sample_t average_current;
  modport source (output valid, duty, sweeping, sweep_done, average_valid,
                  average_voltage, average_current, input ready);
  modport sink   (input valid, duty, sweeping, sweep_done, average_valid,
                  average_voltage, average_current, output ready);
endinterface

>>> hdl/mdss_avg.sv
// Block averager: sums runs of sample pairs and divides by shifting.
// Depends on mdss_pkg.
module mdss_avg (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                start,
  input  mdss_pkg::sample_t   voltage_sample,
  input  mdss_pkg::sample_t   current_sample,
  output mdss_pkg::avg_result_t avg
);
  import mdss_pkg::*;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SAMPLES_PER_AVERAGE - 1);

  logic [SUM_BITS-1:0] voltage_sum;
  logic [SUM_BITS-1:0] current_sum;
  logic [CNT_BITS-1:0] sample_counter;
  logic [SUM_BITS-1:0] voltage_total;
  logic [SUM_BITS-1:0] current_total;
  logic                complete;

  // Running totals including this item
  always_comb begin
    voltage_total = voltage_sum + SUM_BITS'(voltage_sample);
    current_total = current_sum + SUM_BITS'(current_sample);
    complete      = !start && (sample_counter == CNT_LAST);
    avg.valid     = complete;
    avg.voltage   = voltage_total[SUM_BITS-1 -: ADC_BITS];
    avg.current   = current_total[SUM_BITS-1 -: ADC_BITS];
  end

  // Accumulators; cleared by a start command or a finished block
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_sum    <= '0;
      current_sum    <= '0;
      sample_counter <= '0;
    end else if (step) begin
      if (start || complete) begin
        voltage_sum    <= '0;
        current_sum    <= '0;
        sample_counter <= '0;
      end else begin
        voltage_sum    <= voltage_total;
        current_sum    <= current_total;
        sample_counter <= sample_counter + CNT_BITS'(1);
      end
    end
  end

endmodule

>>> hdl/mdss_sweep.sv
// Sweep controller: configuration registers, duty stepping and best-point search.
// Depends on mdss_pkg.
module mdss_sweep (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [mdss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mdss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               step,
  input  logic                               start,
  input  mdss_pkg::avg_result_t              avg,
  output mdss_pkg::sweep_status_t            status
);
  import mdss_pkg::*;

  // Configuration registers
  duty_t                sweep_start;
  logic [STEP_BITS-1:0] duty_step;
  duty_t                duty_max;

  // Sweep state
  duty_t   duty_value, duty_value_next;
  logic    sweep_active, sweep_active_next;
  logic    second_average_flag, second_average_flag_next;
  sample_t first_point_current, first_point_current_next;
  sample_t previous_point_current, previous_point_current_next;
  sample_t best_current, best_current_next;
  duty_t   best_duty, best_duty_next;
  logic    ever_swept;
  logic    done;

  logic [ADC_BITS:0]    point_sum;
  sample_t              point;
  logic [STEP_BITS-1:0] step_eff;
  logic [DUTY_BITS:0]   duty_raise;
  duty_t                duty_clamped;

  // Next sweep state for the item now leaving the input register
  always_comb begin
    duty_value_next             = duty_value;
    sweep_active_next           = sweep_active;
    second_average_flag_next    = second_average_flag;
    first_point_current_next    = first_point_current;
    previous_point_current_next = previous_point_current;
    best_current_next           = best_current;
    best_duty_next              = best_duty;
    done                        = 1'b0;

    point_sum    = {1'b0, first_point_current} + {1'b0, avg.current};
    point        = point_sum[ADC_BITS:1];
    step_eff     = (duty_step == '0) ? STEP_BITS'(1) : duty_step;
    duty_raise   = {1'b0, duty_value} + (DUTY_BITS+1)'(step_eff);
    duty_clamped = (duty_raise > {1'b0, duty_max}) ? duty_max : duty_raise[DUTY_BITS-1:0];

    if (start) begin
      second_average_flag_next    = 1'b0;
      first_point_current_next    = '0;
      previous_point_current_next = '0;
      best_current_next           = '0;
      best_duty_next              = '0;
      if (sweep_start >= duty_max) begin
        // empty sweep: apply the cleared best duty at once
        duty_value_next   = '0;
        sweep_active_next = 1'b0;
        done              = 1'b1;
      end else begin
        duty_value_next   = sweep_start;
        sweep_active_next = 1'b1;
      end
    end else if (avg.valid && sweep_active) begin
      if (!second_average_flag) begin
        first_point_current_next = avg.current;
        second_average_flag_next = 1'b1;
      end else begin
        second_average_flag_next = 1'b0;
        if (point > previous_point_current && point > best_current) begin
          best_current_next = point;
          best_duty_next    = duty_value;
        end
        previous_point_current_next = point;
        if (duty_clamped >= duty_max) begin
          duty_value_next   = best_duty_next;
          sweep_active_next = 1'b0;
          done              = 1'b1;
        end else begin
          duty_value_next = duty_clamped;
        end
      end
    end

    status.duty     = duty_value_next;
    status.sweeping = sweep_active_next;
    status.done     = done;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_start  <= SWEEP_START_RST;
      duty_step    <= DUTY_STEP_RST;
      duty_max     <= DUTY_MAX_RST;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_SWEEP_START:  sweep_start  <= cfg_data;
        CFG_DUTY_STEP:    duty_step    <= cfg_data[STEP_BITS-1:0];
        CFG_DUTY_MAX:     duty_max     <= cfg_data;
        // only steers the driven duty, handled with the sweep state
        CFG_INITIAL_DUTY: ;
        default: ;
      endcase
    end
  end

  // Sweep state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_value             <= INITIAL_DUTY_RST;
      sweep_active           <= 1'b0;
      second_average_flag    <= 1'b0;
      first_point_current    <= '0;
      previous_point_current <= '0;
      best_current           <= '0;
      best_duty              <= '0;
      ever_swept             <= 1'b0;
    end else if (step) begin
      duty_value             <= duty_value_next;
      sweep_active           <= sweep_active_next;
      second_average_flag    <= second_average_flag_next;
      first_point_current    <= first_point_current_next;
      previous_point_current <= previous_point_current_next;
      best_current           <= best_current_next;
      best_duty              <= best_duty_next;
      if (start) begin
        ever_swept <= 1'b1;
      end
    end else if (cfg_write_en && cfg_index_t'(cfg_index) == CFG_INITIAL_DUTY && !ever_swept) begin
      // initial duty drives the PWM until the first sweep
      duty_value <= cfg_data;
    end
  end

endmodule

>>> hdl/mppt_duty_sweep_search_unit.sv
// MPPT duty sweep search unit: top level with input and result registers.
// Depends on mdss_pkg, mdss_if, mdss_avg and mdss_sweep.
//
// Usage:
//   samples  - sink channel; each transaction is either one ADC voltage and
//              current sample pair (action 0) or a sweep start command (action 1).
//   results  - source channel; exactly one transaction per input transaction,
//              in order: driven duty, sweep status, sweep-done flag and the
//              latest 32-sample voltage and current averages.
//   cfg_*    - register write port (sweep_start, duty_step, duty_max,
//              initial_duty); write only while no transaction is in flight.
// Result path: an accepted transaction loads the input register, then moves into
//   the result register when that register advances, which offers it from then on.
// Throughput: one transaction per cycle while results is not stalled; the averager
//   and the sweep compare both sit between the input register and the result register.
// Reset (rst, synchronous): registers return to their defaults, the duty
//   returns to the initial_duty reset value, averages and the sweep state clear.
// When results is stalled the result register holds and the input register
//   still fills; samples.ready drops only once both are full.
module mppt_duty_sweep_search_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [mdss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mdss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  mdss_sample_if.sink                        samples,
  mdss_result_if.source                      results
);
  import mdss_pkg::*;

  // Input register
  logic    in_valid;
  logic    in_action;
  sample_t in_voltage;
  sample_t in_current;

  // Result register
  logic    out_valid;
  duty_t   out_duty;
  logic    out_sweeping;
  logic    out_done;
  logic    out_avg_valid;
  sample_t out_avg_voltage;
  sample_t out_avg_current;

  logic          advance;
  logic          step;
  logic          start;
  avg_result_t   avg;
  sweep_status_t status;

  assign advance       = !out_valid || results.ready;
  assign step          = in_valid && advance;
  assign start         = (action_t'(in_action) == ACT_START);
  assign samples.ready = !in_valid || advance;

  mdss_avg u_avg (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .start          (start),
    .voltage_sample (in_voltage),
    .current_sample (in_current),
    .avg            (avg)
  );

  mdss_sweep u_sweep (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .start        (start),
    .avg          (avg),
    .status       (status)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_action  <= samples.action;
      in_voltage <= samples.voltage_sample;
      in_current <= samples.current_sample;
    end
  end

  // Result register; the average fields also keep the latest averages
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      out_avg_voltage <= '0;
      out_avg_current <= '0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (step && avg.valid) begin
        out_avg_voltage <= avg.voltage;
        out_avg_current <= avg.current;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_duty      <= status.duty;
      out_sweeping  <= status.sweeping;
      out_done      <= status.done;
      out_avg_valid <= avg.valid;
    end
  end

  assign results.valid           = out_valid;
  assign results.duty            = out_duty;
  assign results.sweeping        = out_sweeping;
  assign results.sweep_done      = out_done;
  assign results.average_valid   = out_avg_valid;
  assign results.average_voltage = out_avg_voltage;
  assign results.average_current = out_avg_current;

endmodule
